FILE: rtl/char_lcd_nibble_write_sequencer_defines.svh
// Assertion helpers used by the checker file.
// Both macros sample on clk_i and are disabled while rst_ni is low.
`ifndef CHAR_LCD_NIBBLE_WRITE_SEQUENCER_DEFINES_SVH
`define CHAR_LCD_NIBBLE_WRITE_SEQUENCER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LCDNW_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lcdnw assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define LCDNW_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lcdnw assertion failed");

`endif

FILE: rtl/lcdnw_pkg.sv
`default_nettype none
package lcdnw_pkg;

  localparam int unsigned LCDNW_QUEUE_DEPTH = 4;
  localparam int unsigned MaxColumn = 19;

  typedef enum logic [2:0] {
    OP_COMMAND = 3'd0,
    OP_RAW     = 3'd1,
    OP_TEXT    = 3'd2,
    OP_CURSOR  = 3'd3,
    OP_POWERUP = 3'd4
  } opcode_e;

  localparam logic [1:0] CFG_CMD_HOLD  = 2'd0;
  localparam logic [1:0] CFG_DATA_HOLD = 2'd1;
  localparam logic [1:0] CFG_INIT_HOLD = 2'd2;

  localparam logic [7:0] ROW0_ADDR  = 8'h80;
  localparam logic [7:0] ROW1_ADDR  = 8'hC0;
  localparam logic [7:0] CYR_FIRST  = 8'hC0;
  localparam logic [7:0] LBRACE     = 8'h7B;
  localparam logic [7:0] LBRACE_MAP = 8'hB1;
  localparam logic [7:0] RBRACE     = 8'h7D;
  localparam logic [7:0] RBRACE_MAP = 8'hC7;

  localparam logic [7:0] INIT_CMD0 = 8'h0C;
  localparam logic [7:0] INIT_CMD1 = 8'h01;
  localparam logic [7:0] INIT_CMD2 = 8'h04;
  localparam logic [3:0] INIT_NIB_A = 4'h2;
  localparam logic [3:0] INIT_NIB_B = 4'h8;

  localparam int unsigned STEP_W = 5;
  localparam logic [STEP_W-1:0] BYTE_LAST_STEP = 5'd3;
  localparam logic [STEP_W-1:0] INIT_LAST_STEP = 5'd17;
  localparam logic [STEP_W-1:0] INIT_BARE_STEPS = 5'd6;
  localparam logic [STEP_W-1:0] INIT_NIB_B_STEP = 5'd4;

  typedef enum logic {
    JOB_BYTE,
    JOB_INIT
  } job_kind_e;

  typedef enum logic {
    HOLD_CMD,
    HOLD_DATA
  } hold_sel_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_BYTE,
    BK_INIT
  } back_state_e;

  typedef struct packed {
    job_kind_e  kind;
    logic       rs;
    logic [7:0] data;
    hold_sel_e  hold_sel;
  } job_t;

  typedef struct packed {
    logic [7:0] cmd_hold;
    logic [7:0] data_hold;
    logic [7:0] init_hold;
  } hold_cfg_t;

  localparam logic [7:0] CYR_ROM [64] = '{
    8'h41, 8'hA0, 8'h42, 8'hA1, 8'hE0, 8'h45, 8'hA3, 8'hA4,
    8'hA5, 8'hA6, 8'h4B, 8'h02, 8'h4D, 8'h48, 8'h4F, 8'h03,
    8'h50, 8'h43, 8'h54, 8'hA9, 8'hAA, 8'h58, 8'hE1, 8'hAB,
    8'hAC, 8'hE2, 8'hAD, 8'hAE, 8'h06, 8'hAF, 8'hB0, 8'hB1,
    8'h61, 8'hB2, 8'hB3, 8'hB4, 8'hE3, 8'h65, 8'hB6, 8'hB7,
    8'hB8, 8'hB9, 8'hBA, 8'hBB, 8'hBC, 8'hBD, 8'h6F, 8'hBE,
    8'h70, 8'h63, 8'hBF, 8'h79, 8'h04, 8'h78, 8'hE5, 8'hC0,
    8'hC1, 8'hE6, 8'hC2, 8'hC3, 8'hC4, 8'hC5, 8'hC6, 8'hC7
  };

  // Map a Windows-1251 code to the display character set.
  function automatic logic [7:0] transcode(input logic [7:0] v);
    logic [7:0] t;
    t = (v >= CYR_FIRST) ? CYR_ROM[v[5:0]] : v;
    if (t == LBRACE) begin
      t = LBRACE_MAP;
    end else if (t == RBRACE) begin
      t = RBRACE_MAP;
    end
    return t;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/lcdnw_front.sv
`default_nettype none
// Classify one operation into a queued byte job or a power-up job; opcodes 5 to 7 give no job.
module lcdnw_front (
  input  logic [2:0]        opcode_i,
  input  logic [7:0]        value_i,
  input  logic              row_i,
  input  logic [7:0]        column_i,
  output logic              job_valid_o,
  output lcdnw_pkg::job_t   job_o
);
  import lcdnw_pkg::*;

  logic [7:0] col_clamped;
  logic [7:0] cursor_addr;

  assign col_clamped = (column_i > 8'(MaxColumn)) ? 8'(MaxColumn) : column_i;
  assign cursor_addr = (row_i ? ROW1_ADDR : ROW0_ADDR) + col_clamped;

  always_comb begin
    job_valid_o   = 1'b1;
    job_o.kind    = JOB_BYTE;
    job_o.rs      = 1'b0;
    job_o.data    = value_i;
    job_o.hold_sel = HOLD_CMD;
    case (opcode_i)
      OP_COMMAND: begin
      end
      OP_RAW: begin
        job_o.rs       = 1'b1;
        job_o.hold_sel = HOLD_DATA;
      end
      OP_TEXT: begin
        job_o.rs       = 1'b1;
        job_o.data     = transcode(value_i);
        job_o.hold_sel = HOLD_DATA;
      end
      OP_CURSOR: begin
        job_o.data = cursor_addr;
      end
      OP_POWERUP: begin
        job_o.kind = JOB_INIT;
      end
      default: begin
        job_valid_o = 1'b0;
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/lcdnw_queue.sv
`default_nettype none
// Small job FIFO between front and back.
module lcdnw_queue #(
  parameter int unsigned DEPTH = lcdnw_pkg::LCDNW_QUEUE_DEPTH
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  lcdnw_pkg::job_t push_job_i,
  input  logic            pop_i,
  output lcdnw_pkg::job_t head_o,
  output logic            empty_o,
  output logic            full_o
);
  import lcdnw_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] PtrMax = PtrW'(DEPTH - 1);

  job_t            mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == CntW'(DEPTH));
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrMax) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrMax) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/lcdnw_back.sv
`default_nettype none
// Expand queued jobs into bus states, one beat per cycle.
module lcdnw_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lcdnw_pkg::hold_cfg_t cfg_i,
  input  lcdnw_pkg::job_t      head_i,
  input  logic                 empty_i,
  output logic                 pop_o,
  output logic                 result_valid_o,
  output logic                 register_select_o,
  output logic [3:0]           bus_nibble_o,
  output logic                 enable_o,
  output logic [7:0]           hold_ticks_o,
  output logic                 last_o
);
  import lcdnw_pkg::*;

  back_state_e       state_q, state_d;
  job_t              cur_q, cur_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [STEP_W-1:0] init_ofs;
  logic [7:0]        init_byte;
  logic              emit, at_end;
  logic              beat_rs, beat_en, beat_last;
  logic [3:0]        beat_nib;
  logic [7:0]        beat_hold;

  assign emit   = (state_q != BK_IDLE);
  assign at_end = ((state_q == BK_BYTE) && (step_q == BYTE_LAST_STEP)) ||
                  ((state_q == BK_INIT) && (step_q == INIT_LAST_STEP));
  assign pop_o  = ((state_q == BK_IDLE) || at_end) && !empty_i;
  assign init_ofs = step_q - INIT_BARE_STEPS;

  always_comb begin
    case (init_ofs[4:2])
      3'd0:    init_byte = INIT_CMD0;
      3'd1:    init_byte = INIT_CMD1;
      default: init_byte = INIT_CMD2;
    endcase
  end

  // Beat contents for the current step.
  always_comb begin
    beat_rs   = cur_q.rs;
    beat_last = at_end;
    beat_nib  = step_q[1] ? cur_q.data[3:0] : cur_q.data[7:4];
    beat_en   = ~step_q[0];
    beat_hold = (cur_q.hold_sel == HOLD_DATA) ? cfg_i.data_hold : cfg_i.cmd_hold;
    if (state_q == BK_INIT) begin
      beat_rs = 1'b0;
      if (step_q < INIT_BARE_STEPS) begin
        beat_nib  = (step_q < INIT_NIB_B_STEP) ? INIT_NIB_A : INIT_NIB_B;
        beat_hold = cfg_i.init_hold;
      end else begin
        beat_nib  = init_ofs[1] ? init_byte[3:0] : init_byte[7:4];
        beat_en   = ~init_ofs[0];
        beat_hold = cfg_i.cmd_hold;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    cur_d   = cur_q;
    step_d  = step_q;
    if (pop_o) begin
      cur_d   = head_i;
      step_d  = '0;
      state_d = (head_i.kind == JOB_INIT) ? BK_INIT : BK_BYTE;
    end else if (at_end) begin
      state_d = BK_IDLE;
    end else if (emit) begin
      step_d = step_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= BK_IDLE;
      step_q         <= '0;
      result_valid_o <= 1'b0;
    end else begin
      state_q        <= state_d;
      step_q         <= step_d;
      result_valid_o <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q             <= cur_d;
    register_select_o <= beat_rs;
    bus_nibble_o      <= beat_nib;
    enable_o          <= beat_en;
    hold_ticks_o      <= beat_hold;
    last_o            <= beat_last;
  end

endmodule
`default_nettype wire

FILE: rtl/char_lcd_nibble_write_sequencer.sv
`default_nettype none
// Character LCD 4-bit write sequencer. An operation is taken at a clock edge
// with start high and busy low; busy rises only when the job queue
// (QUEUE_DEPTH entries) is full. Each result beat is one bus state (RS, DB4-DB7,
// E level, hold in 10 us ticks) and sits on the result ports for exactly one
// cycle under result_valid_o; the receiver cannot stall it, so capture every
// strobed beat. A command, raw data, text or cursor operation yields four beats
// in consecutive cycles, power-up yields eighteen, and last_o marks the final
// beat of each operation. The back-end sequencer emits one beat per cycle while
// operations are pending; from idle, an accepted operation passes the job queue,
// the back-end state register and the registered result ports before its first
// beat. Opcodes 5 to 7 are accepted and dropped without any beat. Write the hold
// registers only while no beats are pending.
module char_lcd_nibble_write_sequencer #(
  parameter int unsigned QUEUE_DEPTH = lcdnw_pkg::LCDNW_QUEUE_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] opcode_i,
  input  logic [7:0] value_i,
  input  logic       row_i,
  input  logic [7:0] column_i,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [7:0] cfg_data_i,
  output logic       result_valid_o,
  output logic       register_select_o,
  output logic [3:0] bus_nibble_o,
  output logic       enable_o,
  output logic [7:0] hold_ticks_o,
  output logic       last_o
);
  import lcdnw_pkg::*;

  hold_cfg_t cfg_q, cfg_d;
  job_t      front_job, head_job;
  logic      front_valid, push, pop, q_empty, q_full;

  // Hold registers; writes to the unused index are dropped.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CMD_HOLD:  cfg_d.cmd_hold  = cfg_data_i;
        CFG_DATA_HOLD: cfg_d.data_hold = cfg_data_i;
        CFG_INIT_HOLD: cfg_d.init_hold = cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cmd_hold  <= 8'd1;
      cfg_q.data_hold <= 8'd2;
      cfg_q.init_hold <= 8'd4;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Front: classify and push straight into the queue on the accepting edge.
  lcdnw_front u_front (
    .opcode_i    (opcode_i),
    .value_i     (value_i),
    .row_i       (row_i),
    .column_i    (column_i),
    .job_valid_o (front_valid),
    .job_o       (front_job)
  );

  assign busy = q_full;
  assign push = start && !q_full && front_valid;

  lcdnw_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (front_job),
    .pop_i      (pop),
    .head_o     (head_job),
    .empty_o    (q_empty),
    .full_o     (q_full)
  );

  // Back: advance one beat per cycle, pop the next job on the final beat or while idle.
  lcdnw_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg_q),
    .head_i            (head_job),
    .empty_i           (q_empty),
    .pop_o             (pop),
    .result_valid_o    (result_valid_o),
    .register_select_o (register_select_o),
    .bus_nibble_o      (bus_nibble_o),
    .enable_o          (enable_o),
    .hold_ticks_o      (hold_ticks_o),
    .last_o            (last_o)
  );

endmodule
`default_nettype wire

FILE: rtl/lcdnw_checker.sv
`default_nettype none
`include "char_lcd_nibble_write_sequencer_defines.svh"
module lcdnw_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       result_valid_o,
  input logic       register_select_o,
  input logic [3:0] bus_nibble_o,
  input logic       enable_o,
  input logic [7:0] hold_ticks_o,
  input logic       last_o
);
  logic        e_high;
  logic [12:0] bus_lvl;

  assign e_high  = result_valid_o && enable_o;
  assign bus_lvl = {register_select_o, bus_nibble_o, hold_ticks_o};

  // E high is always followed by E low with the same bus levels.
  `LCDNW_ASSERT_NEXT(a_e_pair, e_high, result_valid_o && !enable_o && $stable(bus_lvl))
  // Beats of one operation come without gaps.
  `LCDNW_ASSERT_NEXT(a_no_gap, result_valid_o && !last_o, result_valid_o)
  // A nibble that is not the last one is followed by a new E-high beat.
  `LCDNW_ASSERT_NEXT(a_next_high, result_valid_o && !last_o && !enable_o, enable_o)
  // An operation never ends on an E-high beat.
  `LCDNW_ASSERT_NOW(a_last_low, e_high, !last_o)
endmodule

bind char_lcd_nibble_write_sequencer lcdnw_checker u_lcdnw_checker (.*);
`default_nettype wire
